// ----- hdl/dfr_pkg.sv -----
// Shared types and constants for the length-prefixed message deframer.
package dfr_pkg;

	localparam int HDR_BYTES = 1 + 4 + 4;
	localparam int LEN_BYTES = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		CFG_KEEPALIVE = 2'd0,
		CFG_FULLLOG   = 2'd1,
		CFG_WIRE      = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		K_HEADER    = 4'd0,
		K_KEEPALIVE = 4'd1,
		K_FILELEN   = 4'd2,
		K_PIECELEN  = 4'd3,
		K_WIRELEN   = 4'd4,
		K_FILEBYTE  = 4'd5,
		K_PIECEBYTE = 4'd6,
		K_WIREBYTE  = 4'd7,
		K_BADTYPE   = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LEN_A = 3'd1,
		PH_LEN_B = 3'd2,
		PH_PAY_A = 3'd3,
		PH_PAY_B = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		TY_NONE = 2'd0,
		TY_FULL = 2'd1,
		TY_WIRE = 2'd2
	} msg_type_t;

	// result of matching a byte against the type codes, keepalive first
	typedef enum logic [1:0] {
		CL_KEEPALIVE = 2'd0,
		CL_FULL      = 2'd1,
		CL_WIRE      = 2'd2,
		CL_BAD       = 2'd3
	} byte_class_t;

	typedef struct packed {
		logic [7:0]  data;
		byte_class_t cls;
	} q_entry_t;

	// queue push word from the front end: valid flag and classified byte
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

endpackage

// ----- hdl/dfr_if.sv -----
// Stream and configuration channel interfaces of the deframer.
interface dfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface dfr_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_kind;
	logic [7:0]  data_out;
	logic [31:0] length_value;
	logic        msg_end;
	modport source (output valid, output event_kind, output data_out, output length_value,
		output msg_end, input ready);
	modport sink (input valid, input event_kind, input data_out, input length_value,
		input msg_end, output ready);
endinterface

interface dfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/dfr_front.sv -----
// Front end: holds the type codes and classifies each incoming byte.
module dfr_front import dfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	output q_push_t    push
);

	logic [7:0]  keepalive_code_q;
	logic [7:0]  fulllog_code_q;
	logic [7:0]  wire_code_q;
	byte_class_t cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepalive_code_q <= 8'd0;
			fulllog_code_q   <= 8'd1;
			wire_code_q      <= 8'd2;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEEPALIVE: keepalive_code_q <= cfg_data;
				CFG_FULLLOG:   fulllog_code_q   <= cfg_data;
				CFG_WIRE:      wire_code_q      <= cfg_data;
				CFG_UNUSED:    ;
			endcase
		end
	end

	always_comb begin
		priority if (data_byte == keepalive_code_q) begin
			cls = CL_KEEPALIVE;
		end else if (data_byte == fulllog_code_q) begin
			cls = CL_FULL;
		end else if (data_byte == wire_code_q) begin
			cls = CL_WIRE;
		end else begin
			cls = CL_BAD;
		end
	end

	assign push.valid      = byte_valid;
	assign push.entry.data = data_byte;
	assign push.entry.cls  = cls;

endmodule

// ----- hdl/dfr_queue.sv -----
// Short flop-based queue of classified words between front and back.
module dfr_queue import dfr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  q_push_t  push,
	output logic     full,
	output logic     not_empty,
	output q_entry_t head,
	input  logic     pop
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/dfr_back.sv -----
// Back end: message state machine and registered result word.
module dfr_back import dfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  q_entry_t    q_head,
	output logic        q_pop,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [3:0]  res_kind,
	output logic [7:0]  res_data,
	output logic [31:0] res_length,
	output logic        res_end
);

	phase_t      phase_q, phase_d;
	msg_type_t   type_q, type_d;
	logic [31:0] shift_q, shift_d;
	logic [1:0]  tok_q, tok_d;
	logic [31:0] first_q, first_d;
	logic [31:0] second_q, second_d;
	logic [31:0] pc_q, pc_d;

	logic        out_valid_q;
	kind_t       kind_q, kind_c;
	logic [7:0]  data_q, data_c;
	logic [31:0] len_q, len_c;
	logic        end_q, end_c;

	logic        step;
	logic        treat_idle;
	logic        tok_done;
	logic [31:0] shift_nx;
	logic [31:0] pc_inc;
	logic [7:0]  b;

	assign b          = q_head.data;
	assign step       = q_not_empty && (!out_valid_q || res_ready);
	assign q_pop      = step;
	assign treat_idle = (phase_q == PH_IDLE) || (phase_q > PH_PAY_B) ||
		!((type_q == TY_FULL) || (type_q == TY_WIRE));
	assign tok_done   = (tok_q == 2'(LEN_BYTES - 1));
	assign shift_nx   = {shift_q[23:0], b};
	assign pc_inc     = pc_q + 32'd1;

	// next state
	always_comb begin
		logic clr;
		clr      = 1'b0;
		phase_d  = phase_q;
		type_d   = type_q;
		shift_d  = shift_q;
		tok_d    = tok_q;
		first_d  = first_q;
		second_d = second_q;
		pc_d     = pc_q;
		if (treat_idle) begin
			clr = 1'b1;
		end else begin
			unique case (phase_q)
				PH_LEN_A: begin
					shift_d = shift_nx;
					tok_d   = tok_q + 2'd1;
					if (tok_done) begin
						first_d = shift_nx;
						shift_d = '0;
						if (type_q == TY_FULL) begin
							phase_d = PH_LEN_B;
						end else if (shift_nx == '0) begin
							clr = 1'b1;
						end else begin
							phase_d = PH_PAY_A;
							pc_d    = '0;
						end
					end
				end
				PH_LEN_B: begin
					shift_d = shift_nx;
					tok_d   = tok_q + 2'd1;
					if (tok_done) begin
						second_d = shift_nx;
						shift_d  = '0;
						pc_d     = '0;
						priority if (first_q != '0) begin
							phase_d = PH_PAY_A;
						end else if (shift_nx != '0) begin
							phase_d = PH_PAY_B;
						end else begin
							clr = 1'b1;
						end
					end
				end
				PH_PAY_A: begin
					pc_d = pc_inc;
					if (pc_inc >= first_q) begin
						if ((type_q == TY_FULL) && (second_q != '0)) begin
							phase_d = PH_PAY_B;
							pc_d    = '0;
						end else begin
							clr = 1'b1;
						end
					end
				end
				PH_PAY_B: begin
					pc_d = pc_inc;
					if (pc_inc >= second_q) begin
						clr = 1'b1;
					end
				end
				default: clr = 1'b1;
			endcase
		end
		if (clr) begin
			phase_d  = PH_IDLE;
			type_d   = TY_NONE;
			shift_d  = '0;
			tok_d    = '0;
			first_d  = '0;
			second_d = '0;
			pc_d     = '0;
		end
		// type byte opens a new message
		if (treat_idle) begin
			unique case (q_head.cls)
				CL_FULL: begin
					type_d  = TY_FULL;
					phase_d = PH_LEN_A;
				end
				CL_WIRE: begin
					type_d  = TY_WIRE;
					phase_d = PH_LEN_A;
				end
				CL_KEEPALIVE, CL_BAD: ;
			endcase
		end
	end

	// result word
	always_comb begin
		kind_c = K_HEADER;
		data_c = '0;
		len_c  = '0;
		end_c  = 1'b0;
		if (treat_idle) begin
			unique case (q_head.cls)
				CL_KEEPALIVE: begin
					kind_c = K_KEEPALIVE;
					end_c  = 1'b1;
				end
				CL_BAD:         kind_c = K_BADTYPE;
				CL_FULL, CL_WIRE: ;
			endcase
		end else begin
			unique case (phase_q)
				PH_LEN_A: begin
					if (tok_done) begin
						len_c = shift_nx;
						if (type_q == TY_FULL) begin
							kind_c = K_FILELEN;
						end else begin
							kind_c = K_WIRELEN;
							end_c  = (shift_nx == '0);
						end
					end
				end
				PH_LEN_B: begin
					if (tok_done) begin
						kind_c = K_PIECELEN;
						len_c  = shift_nx;
						end_c  = (first_q == '0) && (shift_nx == '0);
					end
				end
				PH_PAY_A: begin
					data_c = b;
					kind_c = (type_q == TY_FULL) ? K_FILEBYTE : K_WIREBYTE;
					end_c  = (pc_inc >= first_q) && !((type_q == TY_FULL) && (second_q != '0));
				end
				PH_PAY_B: begin
					data_c = b;
					kind_c = K_PIECEBYTE;
					end_c  = (pc_inc >= second_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			type_q      <= TY_NONE;
			shift_q     <= '0;
			tok_q       <= '0;
			first_q     <= '0;
			second_q    <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q  <= phase_d;
				type_q   <= type_d;
				shift_q  <= shift_d;
				tok_q    <= tok_d;
				first_q  <= first_d;
				second_q <= second_d;
				pc_q     <= pc_d;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q <= kind_c;
			data_q <= data_c;
			len_q  <= len_c;
			end_q  <= end_c;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_kind   = 4'(kind_q);
	assign res_data   = data_q;
	assign res_length = len_q;
	assign res_end    = end_q;

endmodule

// ----- hdl/length_prefixed_message_deframer_core.sv -----
// Each byte passes the queue, then the result register. Throughput: one byte
// per cycle while the queue is not full; the queue and output register let the
// input keep flowing while a result waits, up to QUEUE_DEPTH + 1 bytes in
// flight. Reset (arst_n low): idle awaiting a type byte, codes back to 0/1/2,
// queue and result register empty. Configuration writes are taken every cycle.
module length_prefixed_message_deframer_core import dfr_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dfr_in_if.sink        rx,
	dfr_out_if.source     tx,
	dfr_cfg_if.sink       cfg
);

	q_push_t  push;
	q_entry_t head;
	logic     q_full;
	logic     q_not_empty;
	logic     q_pop;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !q_full;

	dfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.data_byte  (rx.data_byte),
		.byte_valid (rx.valid),
		.push       (push)
	);

	dfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (q_pop)
	);

	dfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (head),
		.q_pop       (q_pop),
		.res_valid   (tx.valid),
		.res_ready   (tx.ready),
		.res_kind    (tx.event_kind),
		.res_data    (tx.data_out),
		.res_length  (tx.length_value),
		.res_end     (tx.msg_end)
	);

endmodule

// ----- hdl/dfr_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
module dfr_checker import dfr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        tx_valid,
	input logic        tx_ready,
	input logic [3:0]  tx_event_kind,
	input logic [7:0]  tx_data_out,
	input logic [31:0] tx_length_value,
	input logic        tx_msg_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_event_kind) &&
		$stable(tx_length_value) && $stable(tx_msg_end))
		else $error("stalled result word changed");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_msg_end |-> tx_event_kind != K_HEADER &&
		tx_event_kind != K_FILELEN && tx_event_kind != K_BADTYPE)
		else $error("message end on a kind that cannot end a message");

	a_len_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_length_value != '0 |-> tx_event_kind == K_FILELEN ||
		tx_event_kind == K_PIECELEN || tx_event_kind == K_WIRELEN)
		else $error("length reported on a non-length word");

	a_data_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_data_out != '0 |-> tx_event_kind == K_FILEBYTE ||
		tx_event_kind == K_PIECEBYTE || tx_event_kind == K_WIREBYTE)
		else $error("payload byte on a non-payload word");

endmodule

bind length_prefixed_message_deframer_core dfr_checker u_dfr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.tx_valid        (tx.valid),
	.tx_ready        (tx.ready),
	.tx_event_kind   (tx.event_kind),
	.tx_data_out     (tx.data_out),
	.tx_length_value (tx.length_value),
	.tx_msg_end      (tx.msg_end)
);

// ----- verif/deframer_checker.sv -----
// Scoreboard for the deframer: predicts one result word per accepted byte and checks them in order.
module deframer_checker import dfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dfr_in_if    rx,
	dfr_out_if   tx,
	dfr_cfg_if   cfg,
	output int   mismatches,
	output int   pending,
	output int   words_checked,
	output int   msgs_ended
);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] len;
		logic        last;
	} deframe_word_t;

	// type codes as last written
	logic [7:0]  code_keepalive;
	logic [7:0]  code_fulllog;
	logic [7:0]  code_wire;

	// message tracking state
	phase_t      fr_phase;
	msg_type_t   fr_type;
	logic [31:0] len_acc;
	logic [1:0]  len_bytes;
	logic [31:0] first_len;
	logic [31:0] second_len;
	logic [31:0] pay_count;

	deframe_word_t expected_words[$];
	int err_cnt;
	int checked_cnt;
	int end_cnt;

	function automatic void drop_message();
		fr_phase   = PH_IDLE;
		fr_type    = TY_NONE;
		len_acc    = '0;
		len_bytes  = '0;
		first_len  = '0;
		second_len = '0;
		pay_count  = '0;
	endfunction

	// shifts in one length byte, true once all four are in
	function automatic logic gather_len_byte(input logic [7:0] b);
		len_acc   = {len_acc[23:0], b};
		len_bytes = len_bytes + 2'd1;
		return len_bytes == 2'd0;
	endfunction

	function automatic deframe_word_t deframe_byte(input logic [7:0] b);
		deframe_word_t w;
		logic type_ok;
		w = '{kind: K_HEADER, data: 8'h00, len: 32'h0, last: 1'b0};
		type_ok = (fr_type == TY_FULL) || (fr_type == TY_WIRE);
		if (fr_phase == PH_IDLE || fr_phase > PH_PAY_B || !type_ok) begin
			drop_message();
			// keepalive wins over full-log, full-log over wire
			if (b == code_keepalive) begin
				w.kind = K_KEEPALIVE;
				w.last = 1'b1;
			end else if (b == code_fulllog) begin
				fr_type  = TY_FULL;
				fr_phase = PH_LEN_A;
			end else if (b == code_wire) begin
				fr_type  = TY_WIRE;
				fr_phase = PH_LEN_A;
			end else begin
				w.kind = K_BADTYPE;
			end
		end else if (fr_phase == PH_LEN_A) begin
			if (gather_len_byte(b)) begin
				w.len     = len_acc;
				first_len = len_acc;
				len_acc   = '0;
				if (fr_type == TY_FULL) begin
					w.kind   = K_FILELEN;
					fr_phase = PH_LEN_B;
				end else begin
					w.kind = K_WIRELEN;
					if (first_len == 32'h0) begin
						w.last = 1'b1;
						drop_message();
					end else begin
						fr_phase  = PH_PAY_A;
						pay_count = '0;
					end
				end
			end
		end else if (fr_phase == PH_LEN_B) begin
			if (gather_len_byte(b)) begin
				w.kind     = K_PIECELEN;
				w.len      = len_acc;
				second_len = len_acc;
				len_acc    = '0;
				pay_count  = '0;
				// an empty file section is skipped
				if (first_len != 32'h0) begin
					fr_phase = PH_PAY_A;
				end else if (second_len != 32'h0) begin
					fr_phase = PH_PAY_B;
				end else begin
					w.last = 1'b1;
					drop_message();
				end
			end
		end else if (fr_phase == PH_PAY_A) begin
			w.data    = b;
			pay_count = pay_count + 32'd1;
			w.kind    = (fr_type == TY_FULL) ? K_FILEBYTE : K_WIREBYTE;
			if (pay_count >= first_len) begin
				if (fr_type == TY_FULL && second_len != 32'h0) begin
					fr_phase  = PH_PAY_B;
					pay_count = '0;
				end else begin
					w.last = 1'b1;
					drop_message();
				end
			end
		end else begin
			w.data    = b;
			w.kind    = K_PIECEBYTE;
			pay_count = pay_count + 32'd1;
			if (pay_count >= second_len) begin
				w.last = 1'b1;
				drop_message();
			end
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deframe_word_t exp_w;
		if (!arst_n) begin
			code_keepalive = 8'd0;
			code_fulllog   = 8'd1;
			code_wire      = 8'd2;
			drop_message();
			expected_words.delete();
			err_cnt       = 0;
			checked_cnt   = 0;
			end_cnt       = 0;
			mismatches    <= 0;
			pending       <= 0;
			words_checked <= 0;
			msgs_ended    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_KEEPALIVE: code_keepalive = cfg.data;
					CFG_FULLLOG:   code_fulllog   = cfg.data;
					CFG_WIRE:      code_wire      = cfg.data;
					default:       ;
				endcase
			end
			if (rx.valid && rx.ready)
				expected_words.push_back(deframe_byte(rx.data_byte));
			if (tx.valid && tx.ready) begin
				if (expected_words.size() == 0) begin
					if (err_cnt < 10)
						$display("[%0t] result word with nothing due: kind %0d data %02h len %08h end %0b",
							$realtime, tx.event_kind, tx.data_out, tx.length_value, tx.msg_end);
					err_cnt++;
				end else begin
					exp_w = expected_words.pop_front();
					checked_cnt++;
					if (exp_w.last)
						end_cnt++;
					if (tx.event_kind !== exp_w.kind || tx.data_out !== exp_w.data ||
							tx.length_value !== exp_w.len || tx.msg_end !== exp_w.last) begin
						if (err_cnt < 10)
							$display("[%0t] word %0d: expected kind %0d data %02h len %08h end %0b, got kind %0d data %02h len %08h end %0b",
								$realtime, checked_cnt, exp_w.kind, exp_w.data, exp_w.len,
								exp_w.last, tx.event_kind, tx.data_out, tx.length_value,
								tx.msg_end);
						err_cnt++;
					end
				end
			end
			mismatches    <= err_cnt;
			pending       <= expected_words.size();
			words_checked <= checked_cnt;
			msgs_ended    <= end_cnt;
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the deframer testbench: clock, reset, byte stream and code writes, result sink, verdict.
module testbench;
	import dfr_pkg::*;

	localparam int PHASE_BYTES     = 210;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 400000;

	// keepalive, full-log, wire codes per setting; includes overlapping codes
	localparam logic [23:0] CODE_SETS [6] = '{
		24'hFF_00_7F, 24'h55_55_AA, 24'h10_20_20, 24'hA5_5A_A5, 24'h00_FF_80, 24'h33_C3_3C
	};

	logic clk;
	logic arst_n;
	int   cycle_cnt = 0;

	dfr_in_if  rx_ch();
	dfr_out_if tx_ch();
	dfr_cfg_if cfg_ch();

	int mismatches;
	int pending;
	int words_checked;
	int msgs_ended;

	bit in_idle      = 1'b1;
	bit out_idle     = 1'b1;
	bit hold_off_req = 1'b0;
	int holds_done   = 0;
	int bytes_sent   = 0;
	int settings_run = 1;

	logic [7:0] cur_ka;
	logic [7:0] cur_full;
	logic [7:0] cur_wire;
	logic [7:0] stream_bytes[$];

	length_prefixed_message_deframer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	deframer_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx_ch),
		.tx            (tx_ch),
		.cfg           (cfg_ch),
		.mismatches    (mismatches),
		.pending       (pending),
		.words_checked (words_checked),
		.msgs_ended    (msgs_ended)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("cycle limit hit with %0d result words still due", pending);
			$display("testbench failed");
			$finish;
		end
	end

	// result sink: random stalls, gap-free stretches, one long hold-off on request
	initial begin
		int stall;
		tx_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_OFF_CYCLES;
				holds_done++;
			end else begin
				stall = out_idle ? $urandom_range(0, 9) : 0;
			end
			if (stall > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			@(posedge clk);
			while (!tx_ch.valid) @(posedge clk);
			if ($urandom_range(0, 63) == 0)
				out_idle = !out_idle;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = in_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid     <= 1'b1;
		rx_ch.data_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
		if ($urandom_range(0, 47) == 0)
			in_idle = !in_idle;
	endtask

	task automatic send_stream();
		while (stream_bytes.size() > 0)
			send_byte(stream_bytes.pop_front());
	endtask

	// pending is registered, so look once past the last accepted byte
	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_code(input cfg_idx_t idx, input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic apply_codes(input logic [7:0] ka, input logic [7:0] fl, input logic [7:0] wr);
		write_code(CFG_KEEPALIVE, ka);
		write_code(CFG_UNUSED, 8'($urandom_range(0, 255)));
		write_code(CFG_FULLLOG, fl);
		write_code(CFG_WIRE, wr);
		cfg_ch.valid <= 1'b0;
		cur_ka   = ka;
		cur_full = fl;
		cur_wire = wr;
		settings_run++;
	endtask

	function automatic bit full_ok();
		return cur_full != cur_ka;
	endfunction

	function automatic bit wire_ok();
		return cur_wire != cur_ka && cur_wire != cur_full;
	endfunction

	function automatic logic [7:0] pick_bad_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == cur_ka || b == cur_full || b == cur_wire);
		return b;
	endfunction

	// mostly short bodies, now and then a long one
	function automatic logic [31:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 8);
		else if (r < 93)
			return $urandom_range(9, 40);
		else if (r < 99)
			return $urandom_range(41, 100);
		return $urandom_range(200, 300);
	endfunction

	function automatic void queue_len32(input logic [31:0] v);
		stream_bytes.push_back(v[31:24]);
		stream_bytes.push_back(v[23:16]);
		stream_bytes.push_back(v[15:8]);
		stream_bytes.push_back(v[7:0]);
	endfunction

	function automatic void queue_body(input int n);
		for (int i = 0; i < n; i++)
			stream_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void queue_wire(input logic [31:0] len, input int n);
		stream_bytes.push_back(cur_wire);
		queue_len32(len);
		queue_body(n);
	endfunction

	function automatic void queue_fulllog(input logic [31:0] flen, input logic [31:0] plen,
			input int n);
		stream_bytes.push_back(cur_full);
		queue_len32(flen);
		queue_len32(plen);
		queue_body(n);
	endfunction

	function automatic void queue_full_random();
		logic [31:0] flen;
		logic [31:0] plen;
		flen = ($urandom_range(0, 5) == 0) ? 32'h0 : pick_len();
		plen = ($urandom_range(0, 5) == 0) ? 32'h0 : pick_len();
		queue_fulllog(flen, plen, int'(flen) + int'(plen));
	endfunction

	function automatic void queue_bad_run(input int n);
		for (int i = 0; i < n; i++)
			stream_bytes.push_back(pick_bad_byte());
	endfunction

	task automatic random_phase();
		int first;
		int r;
		logic [31:0] len;
		first = bytes_sent;
		while (bytes_sent - first < PHASE_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				stream_bytes.push_back(cur_ka);
			end else if (r < 45) begin
				len = pick_len();
				if (wire_ok())
					queue_wire(len, int'(len));
				else
					stream_bytes.push_back(cur_ka);
			end else if (r < 78) begin
				if (full_ok())
					queue_full_random();
				else
					stream_bytes.push_back(cur_ka);
			end else if (r < 88) begin
				queue_bad_run($urandom_range(1, 4));
			end else if (r < 94) begin
				// complete message, if a type code allows one, followed by stray bytes
				len = pick_len();
				if (wire_ok())
					queue_wire(len, int'(len));
				else if (full_ok())
					queue_full_random();
				queue_bad_run($urandom_range(1, 3));
			end else if (r == 94) begin
				wait_drained();
			end else begin
				repeat ($urandom_range(2, 4)) stream_bytes.push_back(cur_ka);
			end
			send_stream();
		end
	endtask

	initial begin
		rx_ch.valid     <= 1'b0;
		rx_ch.data_byte <= 8'h00;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= CFG_KEEPALIVE;
		cfg_ch.data     <= 8'h00;
		arst_n          <= 1'b0;
		cur_ka   = 8'd0;
		cur_full = 8'd1;
		cur_wire = 8'd2;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: keepalive, unknown type, empty wire, empty full-log, one byte per section
		stream_bytes.push_back(cur_ka);
		stream_bytes.push_back(8'hFF);
		queue_wire(32'h0, 0);
		queue_fulllog(32'h0, 32'h0, 0);
		queue_fulllog(32'h1, 32'h1, 2);
		send_stream();

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				wait_drained();
				if (p < 7)
					apply_codes(CODE_SETS[p-1][23:16], CODE_SETS[p-1][15:8],
						CODE_SETS[p-1][7:0]);
				else
					apply_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
			end
			if (p == 2)
				hold_off_req = 1'b1;
			random_phase();
		end

		// huge lengths last: the block is left inside the file section
		wait_drained();
		apply_codes(8'h00, 8'h01, 8'h02);
		queue_fulllog(32'hFFFF_FFFF, 32'h8000_0001, 12);
		send_stream();
		wait_drained();
		repeat (8) @(posedge clk);

		$display("sent %0d stream bytes under %0d code settings with %0d long receiver hold-off(s)",
			bytes_sent, settings_run, holds_done);
		$display("checked %0d result words, %0d messages closed, %0d mismatches",
			words_checked, msgs_ended, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
